// File: sv/crtm_pkg.sv
// ----------------------------------------------------------------------------
// crtm_pkg
// Shared types, codes and helpers for the cidr rule table match block.
// ----------------------------------------------------------------------------
package crtm_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int RSP_IDX_W = 4;
   localparam int ADDR_W = 128;

   localparam logic [7:0] V4_BITS = 8'd32;
   localparam logic [7:0] V6_BITS = 8'd128;

   localparam logic FAM_V4 = 1'b0;
   localparam logic FAM_V6 = 1'b1;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOMATCH   = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_BADPREFIX = 2'd3;

   typedef struct packed {
      logic              family;
      logic [ADDR_W-1:0] net;
      logic [7:0]        prefix;
   } entry_type;

   typedef struct packed {
      logic stop;
      logic hit;
   } match_result_type;

   // top plen bits of the family's address set; prefix assumed in range
   function automatic logic [ADDR_W-1:0] make_mask(input logic fam, input logic [7:0] plen);
      logic [ADDR_W-1:0] m;
      if (fam == FAM_V4) begin
         m = {{(ADDR_W-32){1'b0}}, ~(32'hFFFF_FFFF >> plen)};
      end else begin
         m = ~({ADDR_W{1'b1}} >> plen);
      end
      return m;
   endfunction

   function automatic logic prefix_bad(input logic fam, input logic [7:0] plen);
      return (fam == FAM_V4) ? (plen > V4_BITS) : (plen > V6_BITS);
   endfunction

endpackage

// File: sv/crtm_match_unit.sv
// ----------------------------------------------------------------------------
// crtm_match_unit
// Compares the masked query against one table entry under that entry's mask.
// ----------------------------------------------------------------------------
module crtm_match_unit (
   input  logic                         q_family,
   input  logic [7:0]                   q_prefix,
   input  logic [crtm_pkg::ADDR_W-1:0]  q_addr,
   input  crtm_pkg::entry_type          entry,
   output crtm_pkg::match_result_type   result
);
   import crtm_pkg::*;

   logic [ADDR_W-1:0] entry_mask;
   logic              net_equal;

   assign entry_mask = make_mask(q_family, entry.prefix);
   assign net_equal  = ((q_addr & entry_mask) == entry.net);

   // a net match ends the scan; only a query at least as long is a hit
   assign result.stop = (entry.family == q_family) && net_equal;
   assign result.hit  = result.stop && (q_prefix >= entry.prefix);

endmodule

// File: sv/cidr_rule_table_match_top.sv
// ----------------------------------------------------------------------------
// cidr_rule_table_match_top
// Ordered cidr rule table: append, first-match lookup and clear.
// ----------------------------------------------------------------------------
// append, clear and a lookup that needs no walk go straight to the finish state
// lookup: one rule a cycle through the single compare unit, walking the n rules
//   stored until a net match or the last rule, then on to the finish state
// one request at a time: the request side reopens once the result is staged in the
//   output register, and the finish state waits while that register is full
// reset empties the table (rule count) and the control; rule data is not cleared
module cidr_rule_table_match_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic        req_family,
   input  logic [63:0] req_addr_hi,
   input  logic [63:0] req_addr_lo,
   input  logic [7:0]  req_prefix_len,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [crtm_pkg::RSP_IDX_W-1:0] rsp_match_index
);
   import crtm_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 dvld_ff, dvld_in;
   logic                 q_fam_ff, q_fam_in;
   logic [7:0]           q_plen_ff, q_plen_in;
   logic [ADDR_W-1:0]    q_addr_ff, q_addr_in;
   logic [1:0]           pend_status_ff, pend_status_in;
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [RSP_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;

   entry_type            mem [TABLE_ENTRIES];
   entry_type            rd_entry_ff;
   entry_type            wr_entry;
   logic                 mem_we;
   logic [ADDR_W-1:0]    masked_addr;
   logic [CNT_W-1:0]     last_cnt;
   match_result_type     mres;

   assign masked_addr = {req_addr_hi, req_addr_lo} & make_mask(req_family, req_prefix_len);
   assign wr_entry    = '{family: req_family, net: masked_addr, prefix: req_prefix_len};
   assign last_cnt    = cnt_ff - CNT_W'(1);

   crtm_match_unit u_match (
      .q_family (q_fam_ff),
      .q_prefix (q_plen_ff),
      .q_addr   (q_addr_ff),
      .entry    (rd_entry_ff),
      .result   (mres)
   );

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      ptr_in         = ptr_ff;
      cur_in         = cur_ff;
      dvld_in        = dvld_ff;
      q_fam_in       = q_fam_ff;
      q_plen_in      = q_plen_ff;
      q_addr_in      = q_addr_ff;
      pend_status_in = pend_status_ff;
      pend_idx_in    = pend_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_idx_in     = rsp_idx_ff;
      mem_we         = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in       = S_FINISH;
               pend_status_in = STATUS_NOMATCH;
               pend_idx_in    = '0;
               unique case (req_opcode)
                  OP_APPEND: begin
                     if (prefix_bad(req_family, req_prefix_len)) begin
                        pend_status_in = STATUS_BADPREFIX;
                     end else if (cnt_ff >= CNT_W'(TABLE_ENTRIES)) begin
                        pend_status_in = STATUS_FULL;
                     end else begin
                        mem_we         = 1'b1;
                        pend_status_in = STATUS_OK;
                        pend_idx_in    = cnt_ff[IDX_W-1:0];
                        cnt_in         = cnt_ff + CNT_W'(1);
                     end
                  end
                  OP_LOOKUP: begin
                     if (!prefix_bad(req_family, req_prefix_len) && (cnt_ff != '0)) begin
                        state_in  = S_SCAN;
                        ptr_in    = '0;
                        dvld_in   = 1'b0;
                        q_fam_in  = req_family;
                        q_plen_in = req_prefix_len;
                        q_addr_in = masked_addr;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in         = '0;
                     pend_status_in = STATUS_OK;
                  end
                  default: begin
                     pend_status_in = STATUS_NOMATCH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // rule ptr is read into rd_entry_ff while rule cur, read in the previous cycle, is compared
            dvld_in = 1'b1;
            cur_in  = ptr_ff;
            if (CNT_W'(ptr_ff) != last_cnt) begin
               ptr_in = ptr_ff + IDX_W'(1);
            end
            if (dvld_ff) begin
               if (mres.stop) begin
                  state_in       = S_FINISH;
                  pend_status_in = mres.hit ? STATUS_OK : STATUS_NOMATCH;
                  pend_idx_in    = mres.hit ? cur_ff : '0;
               end else if (CNT_W'(cur_ff) == last_cnt) begin
                  state_in       = S_FINISH;
                  pend_status_in = STATUS_NOMATCH;
                  pend_idx_in    = '0;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_idx_in    = RSP_IDX_W'(pend_idx_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      cur_ff         <= cur_in;
      q_fam_ff       <= q_fam_in;
      q_plen_ff      <= q_plen_in;
      q_addr_ff      <= q_addr_in;
      pend_status_ff <= pend_status_in;
      pend_idx_ff    <= pend_idx_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_idx_ff     <= rsp_idx_in;
   end

   // rule store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[cnt_ff[IDX_W-1:0]] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= mem[ptr_ff];
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_match_index = rsp_idx_ff;

endmodule
